// ===== sv/pcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and codes for the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_OOM      = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic REG_MEM_START = 1'b0;
    localparam logic REG_MEM_END   = 1'b1;

    localparam logic [31:0] MEM_START_RESET = 32'h8000_0000;
    localparam logic [31:0] MEM_END_RESET   = 32'h8800_0000;

    // Access request to one of the state memories
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

// ===== sv/pcpa_head_table.sv =====
// ----------------------------------------------------------------------------
// pcpa_head_table
// List heads, one per CPU, in a synchronous memory, with a non-empty flag
// per CPU in flops so the table itself needs no clearing.
// ----------------------------------------------------------------------------
module pcpa_head_table #(
    parameter int NUM_CPUS  = 8,
    parameter int CW        = 3,
    parameter int HW        = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcpa_pkg::mem_cmd_t  cmd,
    input  logic [CW-1:0]       addr,
    input  logic [HW-1:0]       wdata,
    output logic [HW-1:0]       rdata,
    output logic [NUM_CPUS-1:0] nonempty
);
    import pcpa_pkg::*;

    logic [HW-1:0]       head_mem [NUM_CPUS];
    logic [HW-1:0]       rdata_reg;
    logic [NUM_CPUS-1:0] nonempty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            head_mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= head_mem[addr];
        end
    end

    // Head value zero marks an empty list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
        end
        else if (cmd.wr)
        begin
            nonempty_reg[addr] <= (wdata != '0);
        end
    end

    assign rdata    = rdata_reg;
    assign nonempty = nonempty_reg;

endmodule

// ===== sv/pcpa_link_ram.sv =====
// ----------------------------------------------------------------------------
// pcpa_link_ram
// Successor link of every page, one entry per page, synchronous read.
// ----------------------------------------------------------------------------
module pcpa_link_ram #(
    parameter int MAX_PAGES = 32768,
    parameter int IW        = 15,
    parameter int HW        = 16
) (
    input  logic               clk,
    input  pcpa_pkg::mem_cmd_t cmd,
    input  logic [IW-1:0]      addr,
    input  logic [HW-1:0]      wdata,
    output logic [HW-1:0]      rdata
);
    import pcpa_pkg::*;

    logic [HW-1:0] link_mem [MAX_PAGES];
    logic [HW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            link_mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= link_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/per_cpu_page_allocator.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_allocator
// Page allocator with one LIFO free list per CPU; alloc falls back to the
// lowest-numbered other CPU with a free page.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//  in      | in        | in_valid / in_ready  | command, cpu, phys_addr
//  out     | out       | out_valid / out_ready| status, page_addr, source_cpu
//
//  A bad free or out of memory goes from S_CHECK straight to S_DONE; a good
//  free passes S_PUSH and an alloc S_POP1 and S_POP2: the head read, the link
//  read and the head write-back are serialized through the two memories.
//  One request is in flight at a time; in_ready is high only while idle.
//  A stalled output holds the finished word; the next request is taken once
//  it moves to the output register.
//  Reset empties every list at once through per-CPU flags; no clearing pass.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator #(
    parameter int NUM_CPUS   = 8,
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [2:0]  cpu,
    input  logic [31:0] phys_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] page_addr,
    output logic [2:0]  source_cpu
);
    import pcpa_pkg::*;

    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IW = $clog2(MAX_PAGES);
    localparam int HW = $clog2(MAX_PAGES + 1);

    localparam logic [6:0]  NCPU7 = 7'(NUM_CPUS);
    localparam logic [32:0] PMASK = (33'd1 << PAGE_SHIFT) - 33'd1;
    localparam logic [32:0] MAXP  = 33'(MAX_PAGES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PUSH  = 3'd2;
    localparam logic [2:0] S_POP1  = 3'd3;
    localparam logic [2:0] S_POP2  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   start_reg, end_reg;
    logic          cmd_reg;
    logic [CW-1:0] cpu_reg;
    logic [31:0]   pa_reg;
    logic [32:0]   base_reg;
    logic [CW-1:0] tgt_reg, tgt_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [2:0]    res_src_reg, res_src_next;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_addr_reg;
    logic [2:0]    out_src_reg;

    logic [6:0]    cpu_fold;
    logic [32:0]   base_calc;
    logic [32:0]   rel_diff;
    logic [32:0]   rel_page;
    logic          bad_free;
    logic [CW-1:0] pick;
    logic [32:0]   alloc_addr;

    mem_cmd_t            hd_cmd;
    logic [CW-1:0]       hd_addr;
    logic [HW-1:0]       hd_wdata;
    logic [HW-1:0]       hd_rdata;
    logic [NUM_CPUS-1:0] head_ne;
    mem_cmd_t            lk_cmd;
    logic [IW-1:0]       lk_addr;
    logic [HW-1:0]       lk_wdata;
    logic [HW-1:0]       lk_rdata;

    pcpa_head_table #(
        .NUM_CPUS (NUM_CPUS),
        .CW       (CW),
        .HW       (HW)
    ) u_heads (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (hd_cmd),
        .addr     (hd_addr),
        .wdata    (hd_wdata),
        .rdata    (hd_rdata),
        .nonempty (head_ne)
    );

    pcpa_link_ram #(
        .MAX_PAGES (MAX_PAGES),
        .IW        (IW),
        .HW        (HW)
    ) u_links (
        .clk   (clk),
        .cmd   (lk_cmd),
        .addr  (lk_addr),
        .wdata (lk_wdata),
        .rdata (lk_rdata)
    );

    // Fold the CPU number into range
    always_comb
    begin
        cpu_fold = 7'(cpu);
        for (int i = 0; i < 7; i++)
        begin
            if (cpu_fold >= NCPU7)
            begin
                cpu_fold = cpu_fold - NCPU7;
            end
        end
    end

    assign base_calc = ({1'b0, start_reg} + PMASK) & ~PMASK;
    assign rel_diff  = {1'b0, pa_reg} - base_reg;
    assign rel_page  = rel_diff >> PAGE_SHIFT;
    assign bad_free  = (pa_reg[PAGE_SHIFT-1:0] != '0) || (pa_reg < start_reg) ||
                       (pa_reg >= end_reg) || (rel_page >= MAXP);
    assign alloc_addr = base_reg + ({{(33-IW){1'b0}}, idx_reg} << PAGE_SHIFT);

    // Own list first, else lowest-numbered non-empty list
    always_comb
    begin
        pick = cpu_reg;
        if (!head_ne[cpu_reg])
        begin
            for (int i = NUM_CPUS - 1; i >= 0; i--)
            begin
                if (head_ne[i])
                begin
                    pick = CW'(i);
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        tgt_next        = tgt_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_src_next    = res_src_reg;
        hd_cmd          = '0;
        hd_addr         = cpu_reg;
        hd_wdata        = HW'(idx_reg) + HW'(1);
        lk_cmd          = '0;
        lk_addr         = idx_reg;
        lk_wdata        = head_ne[cpu_reg] ? hd_rdata : '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_status_next = STATUS_DONE;
                res_addr_next   = '0;
                res_src_next    = '0;
                if (cmd_reg == CMD_FREE)
                begin
                    hd_cmd.rd = 1'b1;
                    idx_next  = rel_page[IW-1:0];
                    if (bad_free)
                    begin
                        res_status_next = STATUS_BAD_ADDR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (head_ne == '0)
                begin
                    res_status_next = STATUS_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    hd_cmd.rd  = 1'b1;
                    hd_addr    = pick;
                    tgt_next   = pick;
                    state_next = S_POP1;
                end
            end
            S_PUSH:
            begin
                // Link the page ahead of the old head, then make it the head
                hd_cmd.wr  = 1'b1;
                lk_cmd.wr  = 1'b1;
                state_next = S_DONE;
            end
            S_POP1:
            begin
                idx_next   = IW'(hd_rdata - HW'(1));
                lk_cmd.rd  = 1'b1;
                lk_addr    = idx_next;
                state_next = S_POP2;
            end
            S_POP2:
            begin
                hd_cmd.wr     = 1'b1;
                hd_addr       = tgt_reg;
                hd_wdata      = lk_rdata;
                res_addr_next = alloc_addr[31:0];
                res_src_next  = 3'(tgt_reg);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= MEM_START_RESET;
            end_reg       <= MEM_END_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MEM_START: start_reg <= cfg_wdata;
                    REG_MEM_END:   end_reg   <= cfg_wdata;
                    default:       start_reg <= start_reg;
                endcase
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg  <= command;
            cpu_reg  <= cpu_fold[CW-1:0];
            pa_reg   <= phys_addr;
            base_reg <= base_calc;
        end
        tgt_reg        <= tgt_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_src_reg    <= res_src_next;
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_src_reg    <= res_src_reg;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign page_addr  = out_addr_reg;
    assign source_cpu = out_src_reg;

    a_accept_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_CHECK)
        else $error("accepted request did not start");

    a_pop_from_listed : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP1 |-> head_ne[tgt_reg])
        else $error("pop from an empty list");

    a_push_is_free : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH |-> cmd_reg == CMD_FREE)
        else $error("push on an alloc request");

    a_oom_no_page : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_DONE |->
            out_addr_reg == '0 && out_src_reg == '0)
        else $error("error word carries a page");

    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("request taken while busy");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-CPU page allocator. Directed requests cover
// the address checks, list order, fallback to other CPUs, out of memory and
// window changes. Random alloc/free traffic then runs over several memory
// windows with random stalls on both channels. Every reply is compared
// against a local copy of the free lists.
// ----------------------------------------------------------------------------
module testbench;
    import pcpa_pkg::*;

    localparam int LIST_COUNT    = 8;
    localparam int PAGE_CAPACITY = 32768;
    localparam int PG_SHIFT      = 12;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [32:0] PG_MASK = (33'd1 << PG_SHIFT) - 33'd1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_addr;
        logic [2:0]  source_cpu;
    } page_reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [2:0]  cpu;
    logic [31:0] phys_addr;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] page_addr;
    logic [2:0]  source_cpu;

    // local copy of the allocator state
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [15:0] list_head [LIST_COUNT];
    logic [15:0] page_link [PAGE_CAPACITY];
    int          page_refs [PAGE_CAPACITY];

    page_reply_t owed_replies [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int request_count = 0;
    int kept_frees    = 0;
    int bad_frees     = 0;
    int own_pops      = 0;
    int remote_pops   = 0;
    int oom_replies   = 0;
    int hold_request  = 0;
    bit tx_gaps_on;
    bit rx_gaps_on;

    per_cpu_page_allocator #(
        .NUM_CPUS   (LIST_COUNT),
        .MAX_PAGES  (PAGE_CAPACITY),
        .PAGE_SHIFT (PG_SHIFT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .cpu        (cpu),
        .phys_addr  (phys_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .page_addr  (page_addr),
        .source_cpu (source_cpu)
    );

    always #5 clk = ~clk;

    function automatic logic [32:0] page_base();
        return ({1'b0, win_start} + PG_MASK) & ~PG_MASK;
    endfunction

    // Apply one request to the local lists and return the reply it must give.
    function automatic page_reply_t apply_page_request(logic cmd, logic [2:0] req_cpu,
                                                       logic [31:0] addr);
        page_reply_t reply;
        logic [32:0] base;
        logic [32:0] rel;
        logic [15:0] idx;
        int          src;
        reply = '0;
        reply.status = STATUS_DONE;
        base = page_base();
        if (cmd == CMD_FREE) begin
            if (({1'b0, addr} & PG_MASK) != 0 || addr < win_start || addr >= win_end) begin
                reply.status = STATUS_BAD_ADDR;
                bad_frees++;
            end
            else begin
                rel = ({1'b0, addr} - base) >> PG_SHIFT;
                if (rel >= PAGE_CAPACITY) begin
                    reply.status = STATUS_BAD_ADDR;
                    bad_frees++;
                end
                else begin
                    page_link[rel] = list_head[req_cpu];
                    list_head[req_cpu] = rel[15:0] + 16'd1;
                    page_refs[rel]++;
                    kept_frees++;
                end
            end
        end
        else begin
            src = -1;
            if (list_head[req_cpu] != 0)
                src = req_cpu;
            else
                for (int c = 0; c < LIST_COUNT; c++)
                    if (src < 0 && c != req_cpu && list_head[c] != 0)
                        src = c;
            if (src < 0) begin
                reply.status = STATUS_OOM;
                oom_replies++;
            end
            else begin
                idx = list_head[src] - 16'd1;
                list_head[src] = page_link[idx];
                page_refs[idx]--;
                reply.page_addr  = base[31:0] + ({16'd0, idx} << PG_SHIFT);
                reply.source_cpu = src[2:0];
                if (src == req_cpu)
                    own_pops++;
                else
                    remote_pops++;
            end
        end
        return reply;
    endfunction

    // Pick a page inside the current window that is on no list.
    function automatic bit pick_free_page(output logic [31:0] addr);
        logic [32:0] base;
        int          count;
        int          span;
        int          k;
        base = page_base();
        addr = '0;
        if (base >= {1'b0, win_end})
            return 1'b0;
        count = int'((({1'b0, win_end} - base) + PG_MASK) >> PG_SHIFT);
        if (count > PAGE_CAPACITY)
            count = PAGE_CAPACITY;
        // keep to a low window so pages cycle through the lists; now and then go wide
        span = ($urandom_range(0, 9) == 0) ? count : ((count < 192) ? count : 192);
        for (int t = 0; t < 6; t++) begin
            k = (t == 0 && $urandom_range(0, 19) == 0) ? count - 1
                                                       : $urandom_range(0, span - 1);
            if (page_refs[k] == 0) begin
                addr = base[31:0] + (32'(k) << PG_SHIFT);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_request(logic cmd, logic [2:0] req_cpu, logic [31:0] addr);
        int gap;
        in_valid  <= 1'b1;
        command   <= cmd;
        cpu       <= req_cpu;
        phys_addr <= addr;
        do @(posedge clk); while (!in_ready);
        owed_replies.push_back(apply_page_request(cmd, req_cpu, addr));
        request_count++;
        // hold valid high when the next word follows at once
        gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_window(logic [31:0] start_addr, logic [31:0] end_addr);
        wait_for_replies();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MEM_START;
        cfg_wdata <= start_addr;
        @(posedge clk);
        cfg_index <= REG_MEM_END;
        cfg_wdata <= end_addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_start = start_addr;
        win_end   = end_addr;
    endtask

    task automatic run_random_traffic(int items);
        int          free_pct;
        int          roll;
        logic [31:0] addr;
        free_pct = 50;
        for (int n = 0; n < items; n++) begin
            // swing between filling and draining the lists
            if (n % 40 == 0)
                free_pct = $urandom_range(15, 85);
            roll = $urandom_range(0, 99);
            addr = $urandom;
            if (roll < 12) begin
                if (roll < 6)
                    addr[PG_SHIFT-1:0] = '0;
                send_request(CMD_FREE, 3'($urandom), addr);
            end
            else if (roll < 12 + free_pct * 88 / 100 && pick_free_page(addr))
                send_request(CMD_FREE, 3'($urandom), addr);
            else
                send_request(CMD_ALLOC, 3'($urandom), $urandom);
        end
    endtask

    task automatic test_empty_lists();
        send_request(CMD_ALLOC, 3'd0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 3'd7, 32'h0000_0000);
    endtask

    task automatic test_free_address_checks();
        send_request(CMD_FREE, 3'd1, 32'h8000_0800);
        send_request(CMD_FREE, 3'd2, 32'h7FFF_F000);
        send_request(CMD_FREE, 3'd3, 32'h8800_0000);
        send_request(CMD_FREE, 3'd4, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 3'd5, 32'h0000_0000);
        send_request(CMD_FREE, 3'd7, 32'h8000_0000);
        send_request(CMD_FREE, 3'd7, 32'h87FF_F000);
        send_request(CMD_ALLOC, 3'd7, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd7, 32'h0000_0000);
    endtask

    task automatic test_fallback_order();
        send_request(CMD_FREE, 3'd5, 32'h8000_1000);
        send_request(CMD_FREE, 3'd1, 32'h8000_2000);
        send_request(CMD_ALLOC, 3'd3, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd0, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd0, 32'h0000_0000);
    endtask

    // same page freed on two CPUs while both lists are empty: no loop forms
    task automatic test_cross_cpu_double_free();
        send_request(CMD_FREE, 3'd2, 32'h8000_4000);
        send_request(CMD_FREE, 3'd6, 32'h8000_4000);
        send_request(CMD_ALLOC, 3'd2, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd6, 32'h0000_0000);
    endtask

    task automatic test_window_changes();
        program_window(MEM_START_RESET, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 3'd4, 32'h8800_0000);
        send_request(CMD_FREE, 3'd4, 32'h87FF_F000);
        send_request(CMD_FREE, 3'd4, 32'h8000_0000);
        // listed pages keep their index; the address follows the new base
        program_window(32'h0000_0001, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 3'd4, 32'h0000_0000);
        program_window(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(CMD_ALLOC, 3'd4, 32'h0000_0000);
        send_request(CMD_FREE, 3'd4, 32'hFFFF_F000);
    endtask

    task automatic test_random_default_window();
        program_window(MEM_START_RESET, MEM_END_RESET);
        run_random_traffic(600);
    endtask

    task automatic test_random_full_range();
        program_window(32'h0000_0000, 32'hFFFF_FFFF);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random_traffic(350);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_random_small_windows();
        logic [31:0] start_addr;
        logic [32:0] top;
        for (int p = 0; p < 6; p++) begin
            start_addr = $urandom;
            top = {1'b0, start_addr} + 33'($urandom_range(1, 400)) * 33'd4096;
            if (p % 2 == 0)
                program_window(start_addr, top[32] ? 32'hFFFF_FFFF : top[31:0]);
            else
                program_window(start_addr, $urandom);
            run_random_traffic(50);
        end
    endtask

    task automatic test_output_backpressure();
        program_window(MEM_START_RESET, MEM_END_RESET);
        tx_gaps_on   = 1'b0;
        hold_request = 300;
        run_random_traffic(60);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_random_traffic(100);
        wait_for_replies();
        run_random_traffic(100);
    endtask

    task automatic test_top_page_window();
        program_window(32'hFFFF_F000, 32'hFFFF_FFFF);
        run_random_traffic(100);
        program_window(32'hFFFF_FFFF, 32'h0000_0000);
        run_random_traffic(60);
    endtask

    // a page freed twice on one CPU links to itself; run this last
    task automatic test_self_looping_list();
        logic [31:0] addr;
        program_window(MEM_START_RESET, MEM_END_RESET);
        if (!pick_free_page(addr))
            addr = MEM_START_RESET;
        send_request(CMD_FREE, 3'd0, addr);
        send_request(CMD_FREE, 3'd0, addr);
        repeat (4) send_request(CMD_ALLOC, 3'd0, 32'h0000_0000);
    endtask

    initial begin : reply_sink
        int          stall_left;
        int          hold_left;
        page_reply_t want;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (owed_replies.size() == 0) begin
                    $error("reply word with no request outstanding: status %0d", status);
                    error_count++;
                end
                else begin
                    want = owed_replies.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (page_addr !== want.page_addr) begin
                        $error("page_addr: expected %h, got %h", want.page_addr, page_addr);
                        error_count++;
                    end
                    if (source_cpu !== want.source_cpu) begin
                        $error("source_cpu: expected %0d, got %0d",
                               want.source_cpu, source_cpu);
                        error_count++;
                    end
                end
                stall_left = rx_gaps_on ? $urandom_range(0, 5) : 0;
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("run stopped after %0d cycles, %0d replies outstanding",
                   cycle_count, owed_replies.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_MEM_START;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        command    = CMD_ALLOC;
        cpu        = '0;
        phys_addr  = '0;
        out_ready  = 1'b0;
        win_start  = MEM_START_RESET;
        win_end    = MEM_END_RESET;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        foreach (list_head[i])
            list_head[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lists();
        test_free_address_checks();
        test_fallback_order();
        test_cross_cpu_double_free();
        test_window_changes();
        test_random_default_window();
        test_random_full_range();
        test_random_small_windows();
        test_output_backpressure();
        test_sender_pause();
        test_top_page_window();
        test_self_looping_list();
        wait_for_replies();

        $display("Ran %0d requests across default, full, small, random and top-page windows:",
                 request_count);
        $display("%0d frees listed, %0d rejected; %0d own pops, %0d borrowed, %0d out of memory",
                 kept_frees, bad_frees, own_pops, remote_pops, oom_replies);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
